>>> rtl/lav_pkg.sv
// Shared types, codes and constants of the look-at view matrix block.
package lav_pkg;

	// Internal datapath widths
	localparam int NORM_W = 52;   // signed input of the normalize unit
	localparam int AXIS_W = 18;   // normalized axis element, signed Q2.16 (16 fraction bits) in [-1.0, 1.0]
	localparam int OPA_W  = 34;   // wide multiplier operand
	localparam int PROD_W = 52;   // OPA_W x AXIS_W product
	localparam int ACC_W  = 56;   // multiply-accumulate register
	localparam int RR_W   = 51;   // raw cross product of up and forward
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
		logic signed [31:0] shake_offset;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         matrix_select;
		logic [1:0]         row_index;
		logic signed [31:0] elem_x;
		logic signed [31:0] elem_y;
		logic signed [31:0] elem_z;
		logic [16:0]        elem_w;
		logic               fault;
		logic               last_row;
	} out_item_t;

	// Matrix codes on matrix_select
	typedef enum logic [1:0] {
		MAT_VIEW,
		MAT_FULL_BB,
		MAT_Y_BB
	} mat_sel_t;

	// Work steps of the back end
	typedef enum logic [2:0] {
		OP_NF,    // normalize forward
		OP_XRR,   // up x forward, full precision
		OP_NR,    // normalize right
		OP_XU,    // forward x right
		OP_NUP,   // normalize world up
		OP_XYZ,   // right x normalized up
		OP_DOT    // translation dot products
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_NWAIT,
		S_MAC,
		S_HAND
	} back_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DIV,
		N_DONE
	} norm_state_t;

	// Status of the normalize unit toward the sequencer
	typedef struct packed {
		logic done;
		logic ok;
	} norm_stat_t;

endpackage

>>> rtl/lav_front.sv
// Front end: takes items, applies the shake offset with saturation, forms target minus eye.
module lav_front #(
	parameter int EYE_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lav_pkg::in_item_t    item,
	input  logic                 full,
	output logic                 push,
	output logic [6*EYE_W+3+96-1:0] wdata
);

	localparam logic signed [33:0] MAXV = (34'sd1 <<< (EYE_W - 1)) - 34'sd1;
	localparam logic signed [33:0] MINV = -MAXV - 34'sd1;

	logic [2:0][EYE_W-1:0] eye_s1, tgt_s1;
	logic [2:0][31:0]      up_s1;
	logic                  vld_s1;
	logic [2:0][EYE_W:0]   diff;
	logic                  accept;

	function automatic logic [EYE_W-1:0] shaken(input logic signed [31:0] c,
	                                            input logic signed [31:0] s);
		logic signed [33:0] v;
		v = 34'(c) + 34'(s);
		if (v > MAXV)
			return MAXV[EYE_W-1:0];
		else if (v < MINV)
			return MINV[EYE_W-1:0];
		else
			return v[EYE_W-1:0];
	endfunction

	assign busy   = vld_s1 && full;
	assign accept = start && !busy;
	assign push   = vld_s1 && !full;

	// Stage 1: shaken coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eye_s1[0] <= shaken(item.eye_x, item.shake_offset);
			eye_s1[1] <= shaken(item.eye_y, item.shake_offset);
			eye_s1[2] <= shaken(item.eye_z, item.shake_offset);
			tgt_s1[0] <= shaken(item.target_x, item.shake_offset);
			tgt_s1[1] <= shaken(item.target_y, item.shake_offset);
			tgt_s1[2] <= shaken(item.target_z, item.shake_offset);
			up_s1[0]  <= item.up_x;
			up_s1[1]  <= item.up_y;
			up_s1[2]  <= item.up_z;
		end
	end

	// Direction vector, one bit wider than the coordinates
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = (EYE_W+1)'($signed(tgt_s1[i])) - (EYE_W+1)'($signed(eye_s1[i]));
		end
	end

	assign wdata = {eye_s1, diff, up_s1};

endmodule

>>> rtl/lav_fifo.sv
// Two-entry queue between the front and back ends.
module lav_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

>>> rtl/lav_norm.sv
// Iterative vector normalize unit: range shift, sum of squares, square root, division.
module lav_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [2:0][lav_pkg::NORM_W-1:0]      vec,
	output lav_pkg::norm_stat_t                  stat,
	output logic [2:0][lav_pkg::AXIS_W-1:0]      res
);

	lav_pkg::norm_state_t state_q, state_d;

	logic [2:0][51:0] m_q;
	logic [2:0]       neg_q;
	logic [59:0]      sq_q;
	logic [61:0]      ss_q;
	logic [62:0]      n_q, rt_q, bit_q;
	logic [30:0]      len_q;
	logic [31:0]      rem_q;
	logic [16:0]      dq_q;
	logic [4:0]       step_q;
	logic [1:0]       cnt_q;
	logic             ok_q;
	logic [2:0][lav_pkg::AXIS_W-1:0] res_q;

	logic [51:0] mx;
	logic [62:0] trial;
	logic [46:0] dvd;
	logic [31:0] t;
	logic        tge;
	logic [16:0] dq_n;

	// Largest magnitude, square root trial, division step
	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx)
			mx = m_q[1];
		if (m_q[2] > mx)
			mx = m_q[2];
		trial = rt_q + bit_q;
		dvd   = {1'b0, m_q[cnt_q][29:0], 16'd0} + 47'(len_q >> 1);
		t     = {rem_q[30:0], dq_q[16]};
		tge   = (t >= {1'b0, len_q});
		dq_n  = {dq_q[15:0], tge};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lav_pkg::N_IDLE:  if (start) state_d = lav_pkg::N_SHIFT;
			lav_pkg::N_SHIFT: begin
				if (mx == 52'd0)
					state_d = lav_pkg::N_DONE;
				else if (mx[51:30] == 22'd0 && mx[29])
					state_d = lav_pkg::N_SQ;
			end
			lav_pkg::N_SQ:    if (cnt_q == 2'd3) state_d = lav_pkg::N_SQRT;
			lav_pkg::N_SQRT:  if (bit_q == 63'd0) state_d = lav_pkg::N_DIV;
			lav_pkg::N_DIV:   if (step_q == 5'd17 && cnt_q == 2'd2) state_d = lav_pkg::N_DONE;
			lav_pkg::N_DONE:  state_d = lav_pkg::N_IDLE;
			default:          state_d = lav_pkg::N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lav_pkg::N_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			lav_pkg::N_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= vec[i][51];
					m_q[i]   <= vec[i][51] ? 52'(-vec[i]) : vec[i];
				end
				ok_q  <= 1'b1;
				cnt_q <= 2'd0;
				ss_q  <= 62'd0;
			end
			lav_pkg::N_SHIFT: begin
				if (mx == 52'd0) begin
					ok_q  <= 1'b0;
					res_q <= '0;
				end else if (mx[51:30] != 22'd0) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (!mx[29]) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end
			end
			lav_pkg::N_SQ: begin
				if (cnt_q != 2'd3)
					sq_q <= m_q[cnt_q][29:0] * m_q[cnt_q][29:0];
				if (cnt_q == 2'd3) begin
					n_q   <= {1'b0, ss_q + 62'(sq_q)};
					rt_q  <= 63'd0;
					bit_q <= 63'd1 << 62;
					cnt_q <= 2'd0;
				end else begin
					if (cnt_q != 2'd0)
						ss_q <= ss_q + 62'(sq_q);
					cnt_q <= cnt_q + 2'd1;
				end
			end
			lav_pkg::N_SQRT: begin
				if (bit_q == 63'd0) begin
					len_q  <= rt_q[30:0];
					step_q <= 5'd0;
				end else begin
					if (n_q >= trial) begin
						n_q  <= n_q - trial;
						rt_q <= (rt_q >> 1) + bit_q;
					end else begin
						rt_q <= rt_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			lav_pkg::N_DIV: begin
				if (step_q == 5'd0) begin
					rem_q  <= {2'd0, dvd[46:17]};
					dq_q   <= dvd[16:0];
					step_q <= 5'd1;
				end else begin
					rem_q <= tge ? t - {1'b0, len_q} : t;
					dq_q  <= dq_n;
					if (step_q == 5'd17) begin
						res_q[cnt_q] <= neg_q[cnt_q] ? -{1'b0, dq_n} : {1'b0, dq_n};
						cnt_q  <= cnt_q + 2'd1;
						step_q <= 5'd0;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
			end
			lav_pkg::N_DONE: begin
				cnt_q <= 2'd0;
			end
			default: begin
				cnt_q <= 2'd0;
			end
		endcase
	end

	assign stat.done = (state_q == lav_pkg::N_DONE);
	assign stat.ok   = ok_q;
	assign res       = res_q;

endmodule

>>> rtl/lav_back.sv
// Back end: sequences basis construction and drives the twelve output rows.
module lav_back #(
	parameter int EYE_W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [6*EYE_W+3+96-1:0]  rdata,
	input  logic                     empty,
	output logic                     pop,
	output logic                     strobe,
	output lav_pkg::out_item_t       row
);

	localparam int AW = lav_pkg::AXIS_W;

	lav_pkg::back_state_t state_q, state_d;
	lav_pkg::op_t         op_q;

	logic [2:0][EYE_W-1:0] eye_q;
	logic [2:0][EYE_W:0]   d_q;
	logic [2:0][31:0]      up_q;
	logic [2:0][AW-1:0]    f_q, r_q, u_q, nup_q, yz_q;
	logic [2:0][lav_pkg::RR_W-1:0] rr_q;
	logic [2:0][31:0]      t_q;
	logic                  flt_q;

	logic [1:0] ci_q, cj_q, ph_q;
	logic signed [lav_pkg::PROD_W-1:0] prod_q;
	logic signed [lav_pkg::ACC_W-1:0]  acc_q, acc_n;

	logic [2:0][EYE_W-1:0] eye_w;
	logic [2:0][EYE_W:0]   d_w;
	logic [2:0][31:0]      up_w;

	logic                              nstart;
	logic [2:0][lav_pkg::NORM_W-1:0]   nvec;
	lav_pkg::norm_stat_t               nstat;
	logic [2:0][AW-1:0]                nres;

	logic [1:0] ia, ib;
	logic       sub, last_j, is_norm;
	logic signed [lav_pkg::OPA_W-1:0] opa;
	logic signed [AW-1:0]             opb;
	logic signed [40:0]               rnd;
	logic [31:0]                      sat;

	// Emitter registers
	logic [2:0][AW-1:0] er_q, eu_q, ef_q, en_q, ey_q;
	logic [2:0][31:0]   et_q;
	logic               eflt_q, run_q, em_last, can_load;
	lav_pkg::mat_sel_t  msel_q;
	logic [1:0]         ridx_q;
	lav_pkg::out_item_t row_q, row_d;
	logic               strobe_q;

	function automatic lav_pkg::op_t next_op(input lav_pkg::op_t op);
		unique case (op)
			lav_pkg::OP_NF:  return lav_pkg::OP_XRR;
			lav_pkg::OP_XRR: return lav_pkg::OP_NR;
			lav_pkg::OP_NR:  return lav_pkg::OP_XU;
			lav_pkg::OP_XU:  return lav_pkg::OP_NUP;
			lav_pkg::OP_NUP: return lav_pkg::OP_XYZ;
			lav_pkg::OP_XYZ: return lav_pkg::OP_DOT;
			default:         return lav_pkg::OP_NF;
		endcase
	endfunction

	function automatic logic [1:0] nxt3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	assign {eye_w, d_w, up_w} = rdata;

	lav_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.vec    (nvec),
		.stat   (nstat),
		.res    (nres)
	);

	// Normalize operand select
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			unique case (op_q)
				lav_pkg::OP_NF:  nvec[i] = lav_pkg::NORM_W'($signed(d_q[i]));
				lav_pkg::OP_NR:  nvec[i] = lav_pkg::NORM_W'($signed(rr_q[i]));
				default:         nvec[i] = lav_pkg::NORM_W'($signed(up_q[i]));
			endcase
		end
		is_norm = (op_q == lav_pkg::OP_NF) || (op_q == lav_pkg::OP_NR) ||
		          (op_q == lav_pkg::OP_NUP);
	end

	// Multiply operand select and accumulate
	always_comb begin
		if (op_q == lav_pkg::OP_DOT) begin
			ia     = cj_q;
			ib     = cj_q;
			sub    = 1'b1;
			last_j = (cj_q == 2'd2);
		end else if (cj_q == 2'd0) begin
			ia     = nxt3(ci_q);
			ib     = nxt3(nxt3(ci_q));
			sub    = 1'b0;
			last_j = 1'b0;
		end else begin
			ia     = nxt3(nxt3(ci_q));
			ib     = nxt3(ci_q);
			sub    = 1'b1;
			last_j = 1'b1;
		end
		unique case (op_q)
			lav_pkg::OP_XRR: begin
				opa = lav_pkg::OPA_W'($signed(up_q[ia]));
				opb = $signed(f_q[ib]);
			end
			lav_pkg::OP_XU: begin
				opa = lav_pkg::OPA_W'($signed(f_q[ia]));
				opb = $signed(r_q[ib]);
			end
			lav_pkg::OP_XYZ: begin
				opa = lav_pkg::OPA_W'($signed(r_q[ia]));
				opb = $signed(nup_q[ib]);
			end
			default: begin
				opa = lav_pkg::OPA_W'($signed(eye_q[ia]));
				unique case (ci_q)
					2'd0:    opb = $signed(r_q[ib]);
					2'd1:    opb = $signed(u_q[ib]);
					default: opb = $signed(f_q[ib]);
				endcase
			end
		endcase
		acc_n = sub ? acc_q - lav_pkg::ACC_W'(prod_q) : acc_q + lav_pkg::ACC_W'(prod_q);
	end

	// Q32 to Q16.16, half away from zero, then 32-bit saturation
	always_comb begin
		logic [55:0] mag;
		logic [40:0] q;
		mag = acc_q[55] ? 56'(-acc_q) : 56'(acc_q);
		q   = 41'((mag + 56'd32768) >> 16);
		rnd = acc_q[55] ? -$signed(q) : $signed(q);
		if (rnd > 41'sh0_7FFF_FFFF)
			sat = 32'h7FFF_FFFF;
		else if (rnd < -41'sh0_8000_0000)
			sat = 32'h8000_0000;
		else
			sat = rnd[31:0];
	end

	assign em_last  = run_q && (msel_q == lav_pkg::MAT_Y_BB) && (ridx_q == 2'd3);
	assign can_load = !run_q || em_last;

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		nstart  = 1'b0;
		unique case (state_q)
			lav_pkg::S_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = lav_pkg::S_RUN;
				end
			end
			lav_pkg::S_RUN: begin
				if (is_norm) begin
					nstart  = 1'b1;
					state_d = lav_pkg::S_NWAIT;
				end else begin
					state_d = lav_pkg::S_MAC;
				end
			end
			lav_pkg::S_NWAIT: begin
				if (nstat.done)
					state_d = lav_pkg::S_RUN;
			end
			lav_pkg::S_MAC: begin
				if (ph_q == 2'd2 && ci_q == 2'd2)
					state_d = (op_q == lav_pkg::OP_DOT) ? lav_pkg::S_HAND : lav_pkg::S_RUN;
			end
			lav_pkg::S_HAND: begin
				if (can_load)
					state_d = lav_pkg::S_IDLE;
			end
			default: state_d = lav_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lav_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			lav_pkg::S_IDLE: begin
				eye_q <= eye_w;
				d_q   <= d_w;
				up_q  <= up_w;
				op_q  <= lav_pkg::OP_NF;
				flt_q <= 1'b0;
			end
			lav_pkg::S_RUN: begin
				ci_q  <= 2'd0;
				cj_q  <= 2'd0;
				ph_q  <= 2'd0;
				acc_q <= '0;
			end
			lav_pkg::S_NWAIT: begin
				if (nstat.done) begin
					unique case (op_q)
						lav_pkg::OP_NF: f_q   <= nres;
						lav_pkg::OP_NR: r_q   <= nres;
						default:        nup_q <= nres;
					endcase
					flt_q <= flt_q || !nstat.ok;
					op_q  <= next_op(op_q);
				end
			end
			lav_pkg::S_MAC: begin
				unique case (ph_q)
					2'd0: begin
						prod_q <= opa * opb;
						ph_q   <= 2'd1;
					end
					2'd1: begin
						acc_q <= acc_n;
						if (last_j) begin
							ph_q <= 2'd2;
						end else begin
							cj_q <= cj_q + 2'd1;
							ph_q <= 2'd0;
						end
					end
					default: begin
						unique case (op_q)
							lav_pkg::OP_XRR: rr_q[ci_q] <= acc_q[lav_pkg::RR_W-1:0];
							lav_pkg::OP_XU:  u_q[ci_q]  <= rnd[AW-1:0];
							lav_pkg::OP_XYZ: yz_q[ci_q] <= rnd[AW-1:0];
							default:         t_q[ci_q]  <= sat;
						endcase
						acc_q <= '0;
						cj_q  <= 2'd0;
						ph_q  <= 2'd0;
						ci_q  <= ci_q + 2'd1;
						if (ci_q == 2'd2 && op_q != lav_pkg::OP_DOT)
							op_q <= next_op(op_q);
					end
				endcase
			end
			default: begin
				ph_q <= 2'd0;
			end
		endcase
	end

	// Row select for the emitter
	always_comb begin
		row_d.matrix_select = msel_q;
		row_d.row_index     = ridx_q;
		row_d.fault         = eflt_q;
		row_d.last_row      = em_last;
		row_d.elem_w        = 17'd0;
		row_d.elem_x        = '0;
		row_d.elem_y        = '0;
		row_d.elem_z        = '0;
		if (ridx_q == 2'd3) begin
			row_d.elem_w = lav_pkg::ONE_Q16;
			if (msel_q == lav_pkg::MAT_VIEW) begin
				row_d.elem_x = et_q[0];
				row_d.elem_y = et_q[1];
				row_d.elem_z = et_q[2];
			end
		end else if (msel_q == lav_pkg::MAT_VIEW) begin
			row_d.elem_x = 32'($signed(er_q[ridx_q]));
			row_d.elem_y = 32'($signed(eu_q[ridx_q]));
			row_d.elem_z = 32'($signed(ef_q[ridx_q]));
		end else begin
			logic [2:0][AW-1:0] v;
			unique case (ridx_q)
				2'd0:    v = er_q;
				2'd1:    v = (msel_q == lav_pkg::MAT_Y_BB) ? en_q : eu_q;
				default: v = (msel_q == lav_pkg::MAT_Y_BB) ? ey_q : ef_q;
			endcase
			row_d.elem_x = 32'($signed(v[0]));
			row_d.elem_y = 32'($signed(v[1]));
			row_d.elem_z = 32'($signed(v[2]));
		end
	end

	// Emitter control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			strobe_q <= 1'b0;
			msel_q   <= lav_pkg::MAT_VIEW;
			ridx_q   <= 2'd0;
		end else begin
			strobe_q <= run_q;
			if (state_q == lav_pkg::S_HAND && can_load) begin
				run_q  <= 1'b1;
				msel_q <= lav_pkg::MAT_VIEW;
				ridx_q <= 2'd0;
			end else if (run_q) begin
				ridx_q <= ridx_q + 2'd1;
				if (ridx_q == 2'd3) begin
					unique case (msel_q)
						lav_pkg::MAT_VIEW:    msel_q <= lav_pkg::MAT_FULL_BB;
						lav_pkg::MAT_FULL_BB: msel_q <= lav_pkg::MAT_Y_BB;
						default: begin
							msel_q <= lav_pkg::MAT_VIEW;
							run_q  <= 1'b0;
						end
					endcase
				end
			end
		end
	end

	// Emitter payload
	always_ff @(posedge clk) begin
		row_q <= row_d;
		if (state_q == lav_pkg::S_HAND && can_load) begin
			er_q   <= r_q;
			eu_q   <= u_q;
			ef_q   <= f_q;
			en_q   <= nup_q;
			ey_q   <= yz_q;
			et_q   <= t_q;
			eflt_q <= flt_q;
		end
	end

	assign strobe = strobe_q;
	assign row    = row_q;

endmodule

>>> rtl/look_at_view_matrix_top.sv
// Top level of the left-handed look-at view and billboard matrix block.
//
// Input channel: an item (eye, target, up, shake offset, signed Q16.16) is
// taken at a rising edge with start high and busy low. busy rises only when
// the two-entry queue and the front stage are all holding items.
// Output channel: twelve rows per item, one per cycle on consecutive cycles,
// each marked by strobe for one cycle: view rows 0..3, full billboard rows
// 0..3, y-axis billboard rows 0..3, last_row on the twelfth.
// The receiver cannot stall; rows leave at the strobe cycle without fail.
// The back end runs three normalizations (range shift, 32-step square root
// and three divisions each; a zero axis cuts its normalization short) and
// four cross and dot product passes through one shared multiplier; it takes
// a new item only after handing the last one to the row output. The row
// output of one item overlaps the work on the next, and the front end takes
// up to three items ahead.
// Reset: arst_n clears the queue, sequencer and row strobe; no rows are
// driven until an item has been taken and finished.
module look_at_view_matrix_top #(
	parameter int COORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lav_pkg::in_item_t  item,
	output logic               strobe,
	output lav_pkg::out_item_t row
);

	localparam int EYE_W = (COORD_WIDTH < 33) ? COORD_WIDTH : 33;
	localparam int QW    = 6 * EYE_W + 3 + 96;

	logic          push, pop, full, empty;
	logic [QW-1:0] wdata, rdata;

	lav_front #(.EYE_W(EYE_W)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.full   (full),
		.push   (push),
		.wdata  (wdata)
	);

	lav_fifo #(.W(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	lav_back #(.EYE_W(EYE_W)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rdata  (rdata),
		.empty  (empty),
		.pop    (pop),
		.strobe (strobe),
		.row    (row)
	);

endmodule

>>> tb/tb_look_at_view_matrix_top.sv
// Testbench of the look-at view matrix block: random and directed camera items, row checks.
`timescale 1ns / 1ps

module tb_look_at_view_matrix_top;

	localparam int CW = 32;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	lav_pkg::in_item_t   item;
	logic                strobe;
	lav_pkg::out_item_t  row;

	lav_pkg::in_item_t   pending_items[$];
	lav_pkg::out_item_t  expected_rows[$];
	int         error_count;
	int         sent_count;
	bit         hold_sender;
	bit         calm_stretch;

	look_at_view_matrix_top #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .strobe(strobe), .row(row)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shaken coordinate clamp to the coordinate width
	function automatic longint clamp_coord(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (CW >= 34) return v;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (v < -64'sh80000000) return -64'sh80000000;
		return v;
	endfunction

	// Q32 to Q16.16, half away from zero
	function automatic longint round_q16(longint v);
		longint unsigned m;
		longint unsigned r;
		m = (v < 0) ? longint'(-v) : v;
		r = (m + 32768) >> 16;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Unit vector in Q16.16; returns 0 on a zero vector
	function automatic bit unit_vec(input longint a[3], output longint r[3]);
		longint unsigned m[3];
		longint unsigned mx, ss, len, q;
		bit neg[3];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = a[i] < 0;
			m[i] = neg[i] ? longint'(-a[i]) : a[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			r = '{0, 0, 0};
			return 1'b0;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(ss);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 16) + (len >> 1)) / len;
			r[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void cross_full(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic lav_pkg::out_item_t make_row(lav_pkg::mat_sel_t sel, int idx,
			longint x, longint y, longint z, logic [16:0] w, bit flt, bit last);
		lav_pkg::out_item_t o;
		o.matrix_select = sel;
		o.row_index = idx[1:0];
		o.elem_x = x[31:0];
		o.elem_y = y[31:0];
		o.elem_z = z[31:0];
		o.elem_w = w;
		o.fault = flt;
		o.last_row = last;
		return o;
	endfunction

	// Camera basis and the twelve matrix rows of one item
	function automatic void predict_camera_rows(lav_pkg::in_item_t it);
		longint eye[3], tgt[3], upv[3], d[3], f[3], rr[3], r[3], u[3];
		longint nup[3], yz[3], t[3], acc, shake;
		longint ax[3];
		bit flt;
		shake = longint'(it.shake_offset);
		eye[0] = clamp_coord(longint'(it.eye_x) + shake);
		eye[1] = clamp_coord(longint'(it.eye_y) + shake);
		eye[2] = clamp_coord(longint'(it.eye_z) + shake);
		tgt[0] = clamp_coord(longint'(it.target_x) + shake);
		tgt[1] = clamp_coord(longint'(it.target_y) + shake);
		tgt[2] = clamp_coord(longint'(it.target_z) + shake);
		upv[0] = longint'(it.up_x);
		upv[1] = longint'(it.up_y);
		upv[2] = longint'(it.up_z);
		for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
		flt = 1'b0;
		if (!unit_vec(d, f)) flt = 1'b1;
		cross_full(upv, f, rr);
		if (!unit_vec(rr, r)) flt = 1'b1;
		cross_full(f, r, u);
		for (int i = 0; i < 3; i++) u[i] = round_q16(u[i]);
		if (!unit_vec(upv, nup)) flt = 1'b1;
		cross_full(r, nup, yz);
		for (int i = 0; i < 3; i++) yz[i] = round_q16(yz[i]);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (i == 0)
					ax[j] = r[j];
				else if (i == 1)
					ax[j] = u[j];
				else
					ax[j] = f[j];
			end
			acc = 0;
			for (int j = 0; j < 3; j++) acc += ax[j] * (-eye[j]);
			t[i] = sat_word(round_q16(acc));
		end
		for (int i = 0; i < 3; i++)
			expected_rows.push_back(make_row(lav_pkg::MAT_VIEW, i, r[i], u[i], f[i],
				17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_VIEW, 3, t[0], t[1], t[2],
			lav_pkg::ONE_Q16, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_FULL_BB, 0, r[0], r[1], r[2],
			17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_FULL_BB, 1, u[0], u[1], u[2],
			17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_FULL_BB, 2, f[0], f[1], f[2],
			17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_FULL_BB, 3, 0, 0, 0,
			lav_pkg::ONE_Q16, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_Y_BB, 0, r[0], r[1], r[2],
			17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_Y_BB, 1, nup[0], nup[1], nup[2],
			17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_Y_BB, 2, yz[0], yz[1], yz[2],
			17'd0, flt, 1'b0));
		expected_rows.push_back(make_row(lav_pkg::MAT_Y_BB, 3, 0, 0, 0,
			lav_pkg::ONE_Q16, flt, 1'b1));
	endfunction

	// Driver: pops an item and holds start until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			sent_count <= 0;
		end else begin
			if (start && !busy) sent_count <= sent_count + 1;
			if (!(start && busy)) begin
				if (!hold_sender && pending_items.size() > 0 &&
						(calm_stretch || $urandom_range(99) >= 14)) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Prediction at acceptance
	always @(posedge clk) begin
		if (arst_n && start && !busy) predict_camera_rows(item);
	end

	// Monitor: each strobed row against the oldest expectation
	always @(posedge clk) begin
		lav_pkg::out_item_t want;
		if (arst_n && strobe) begin
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected row, actual %h", $time, row);
				error_count++;
			end else begin
				want = expected_rows.pop_front();
				if (row.matrix_select !== want.matrix_select || row.row_index !== want.row_index
						|| row.elem_x !== want.elem_x || row.elem_y !== want.elem_y
						|| row.elem_z !== want.elem_z || row.elem_w !== want.elem_w
						|| row.fault !== want.fault || row.last_row !== want.last_row) begin
					$display("%0t: row mismatch, expected %h actual %h", $time, want, row);
					error_count++;
				end
			end
		end
	end

	function automatic lav_pkg::in_item_t camera(int ex, int ey, int ez, int tx, int ty,
			int tz, int ux, int uy, int uz, int sh);
		lav_pkg::in_item_t it;
		it = '{ex, ey, ez, tx, ty, tz, ux, uy, uz, sh};
		return it;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(32'h00200000)) - 32'sh00100000;
			2: return $signed($urandom_range(32'h20000)) - 32'sh10000;
			default: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
		endcase
	endfunction

	// Stimulus
	initial begin
		int total;
		lav_pkg::in_item_t it;
		error_count = 0;
		hold_sender = 1'b0;
		calm_stretch = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: plain cameras, degenerate axes, saturating shakes, extremes
		pending_items.push_back(camera(0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0));
		pending_items.push_back(camera(32'h50000, 32'h20000, -32'h30000, 0, 0, 0,
			0, 32'h10000, 0, 32'h8000));
		pending_items.push_back(camera(7, 7, 7, 7, 7, 7, 0, 32'h10000, 0, 0));
		pending_items.push_back(camera(0, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(camera(0, 0, 0, 0, 32'h10000, 0, 0, 32'h30000, 0, 0));
		pending_items.push_back(camera(0, 0, 0, 0, -32'h10000, 0, 0, 32'h10000, 0, 0));
		pending_items.push_back(camera(32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 1, 0,
			32'h7FFFFFFF));
		pending_items.push_back(camera(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1,
			32'h80000000));
		pending_items.push_back(camera(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 0));
		pending_items.push_back(camera(32'h10, 0, 0, 32'h20, 0, 0, 0, 0, -1, 32'h7FFFFFF0));
		pending_items.push_back(camera(-1, -1, -1, 0, 0, 0, 1, 0, 0, 32'h80000000));
		pending_items.push_back(camera(32'h7FFF0000, 32'h7FFF0000, 0, 32'h7FFF0000,
			32'h7FFF0000, 32'h7FFF0000, 0, 0, 32'h10000, 32'h100000));
		pending_items.push_back(camera(-32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000,
			32'h7FFF0000, -32'h7FFF0000, -32'h7FFF0000, 32'h10000, 32'h10000, 0, 0));
		pending_items.push_back(camera(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		pending_items.push_back(camera(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		wait (pending_items.size() == 0 && sent_count == 15);

		// Drain pause: hold off until every row is back
		hold_sender = 1'b1;
		wait (expected_rows.size() == 0);
		@(posedge clk);
		hold_sender = 1'b0;

		// Random: mostly well-formed cameras, some degenerate ones
		total = 15;
		for (int n = 0; n < 235; n++) begin
			for (int k = 0; k < 10; k++) it[k*32 +: 32] = rand_coord();
			case ($urandom_range(9))
				0: begin
					it.target_x = it.eye_x; it.target_y = it.eye_y; it.target_z = it.eye_z;
				end
				1: begin
					it.up_x = 0; it.up_y = 0; it.up_z = 0;
				end
				2: begin
					it.up_x = it.target_x - it.eye_x;
					it.up_y = it.target_y - it.eye_y;
					it.up_z = it.target_z - it.eye_z;
					it.shake_offset = $signed($urandom_range(32'h2000)) - 32'sh1000;
				end
				default: ;
			endcase
			pending_items.push_back(it);
			total++;
			if (n == 60) begin
				calm_stretch = 1'b1;
				wait (pending_items.size() == 0);
			end
			if (n == 120) begin
				calm_stretch = 1'b0;
				wait (pending_items.size() == 0);
			end
		end
		wait (pending_items.size() == 0 && sent_count == total);
		wait (expected_rows.size() == 0);
		repeat (600) @(posedge clk);
		if (error_count == 0 && expected_rows.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Timeout
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
